### sv/aging_neighbor_table_unit_macros.svh
// Assertion macros shared by the aging neighbor table checkers.
`ifndef AGING_NEIGHBOR_TABLE_UNIT_MACROS_SVH
`define AGING_NEIGHBOR_TABLE_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ANT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neighbor table check failed");

// Consequent checked in the cycle after the antecedent.
`define ANT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neighbor table check failed");

`endif

### sv/ant_pkg.sv
// Package: types, codes and defaults for the aging neighbor table.
package ant_pkg;

    localparam int unsigned ANT_TABLE_DEPTH = 16;

    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_REFRESH = 3'd1;
    localparam logic [2:0] KIND_INSERT  = 3'd2;
    localparam logic [2:0] KIND_QUERY   = 3'd3;
    localparam logic [2:0] KIND_TX_ERR  = 3'd4;

    localparam logic REG_PURGE_PERIOD = 1'b0;
    localparam logic REG_REPORT       = 1'b1;

    localparam logic RES_FINAL  = 1'b0;
    localparam logic RES_REPORT = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] neighbor_address;
        logic [15:0] hold_time;
        logic [47:0] link_mac;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] reported_address;
        logic        present;
        logic [31:0] remaining_time;
        logic        table_full;
        logic        last;
    } t_result;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        refresh;
        logic        close;
        logic        insert;
        logic        purge_one;
        logic        purge_all;
        logic [31:0] key;
        logic [47:0] mac;
        logic [31:0] new_exp;
        logic [31:0] now;
    } t_cell_cmd;

    // Passed from each cell to the next one up the row.
    typedef struct packed {
        logic        any_valid;
        logic        dead_seen;
        logic        free_seen;
        logic        hit;
        logic [31:0] rep_addr;
        logic [31:0] hit_exp;
    } t_chain;

endpackage

### sv/aging_neighbor_table_unit.sv
// Top level: aging neighbor table with purge reporting and APB registers.
//
// Usage: an item word is taken at a clock edge with start high and busy low.
// Each item yields zero or more link failure reports (result_kind 1), then one
// final answer with last set; every result word shows on o_result for one
// cycle, flagged by o_res_valid. The receiver cannot stall the block.
// An accepted item passes S_PRE, then S_PURGE when a purge runs, then
// S_FINAL, which registers the final answer; the next item is taken in the
// cycle the final answer is registered. The pace is set by the row of slot
// cells: with reporting on, one lowest-dead slot leaves the row per cycle,
// picked by a priority chain that runs through the cells; with reporting
// off, all dead slots leave the row at once.
// Registers: 0x0 purge_period (16 bit), 0x4 report_failures (1 bit); write
// only while the block is idle. pready is always high.
// Reset: all slots invalid, time 0, purge countdown 1, purge_period 1,
// report_failures 1. No clearing pass is needed.
module aging_neighbor_table_unit
    import ant_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = ANT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_res_valid,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PRE   = 2'd1;
    localparam logic [1:0] S_PURGE = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0]  r_state;
    logic [1:0]  n_state;
    t_item       r_item;
    logic        r_hit;
    logic        n_hit;
    logic [31:0] r_time;
    logic [31:0] n_time;
    logic [15:0] r_cnt;
    logic [15:0] n_cnt;
    logic [15:0] r_period;
    logic        r_report;
    logic        r_res_valid;
    logic        n_res_valid;
    t_result     r_result;
    t_result     n_result;

    t_cell_cmd   w_cmd;
    t_chain      w_chain [TABLE_DEPTH+1];
    t_chain      w_end;
    logic [32:0] w_sum;
    logic [31:0] w_new_exp;
    logic        w_accept;
    logic        w_cfg_wr;

    assign w_accept = start && !busy;
    assign busy     = (r_state == S_PRE) || (r_state == S_PURGE);
    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_REPORT) ? {31'd0, r_report} : {16'd0, r_period};

    assign w_sum     = {1'b0, r_time} + {17'd0, r_item.hold_time};
    assign w_new_exp = w_sum[32] ? '1 : w_sum[31:0];

    assign w_chain[0] = '0;
    assign w_end      = w_chain[TABLE_DEPTH];

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ant_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_hit       = r_hit;
        n_time      = r_time;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_result    = '0;
        w_cmd         = '0;
        w_cmd.key     = r_item.neighbor_address;
        w_cmd.mac     = r_item.link_mac;
        w_cmd.new_exp = w_new_exp;
        w_cmd.now     = r_time;

        unique case (r_state)
            S_PRE: begin
                n_hit   = w_end.hit;
                n_state = S_FINAL;
                unique case (r_item.kind)
                    KIND_TICK: begin
                        n_time = (r_time == '1) ? r_time : r_time + 32'd1;
                        if (r_cnt <= 16'd1) begin
                            n_cnt   = 16'd0;
                            n_state = S_PURGE;
                        end else begin
                            n_cnt = r_cnt - 16'd1;
                        end
                    end
                    KIND_REFRESH: begin
                        w_cmd.refresh = 1'b1;
                    end
                    KIND_INSERT: begin
                        w_cmd.refresh = 1'b1;
                        if (!w_end.hit) begin
                            n_state = S_PURGE;
                        end
                    end
                    KIND_QUERY: begin
                        n_state = S_PURGE;
                    end
                    KIND_TX_ERR: begin
                        w_cmd.close = 1'b1;
                        n_state     = S_PURGE;
                    end
                    default: begin
                    end
                endcase
            end
            S_PURGE: begin
                if (w_end.any_valid) begin
                    n_cnt = r_period;
                end
                if (!w_end.dead_seen) begin
                    n_state = S_FINAL;
                end else if (r_report) begin
                    w_cmd.purge_one           = 1'b1;
                    n_res_valid               = 1'b1;
                    n_result.result_kind      = RES_REPORT;
                    n_result.reported_address = w_end.rep_addr;
                end else begin
                    w_cmd.purge_all = 1'b1;
                    n_state         = S_FINAL;
                end
            end
            S_FINAL: begin
                n_res_valid          = 1'b1;
                n_result.result_kind = RES_FINAL;
                n_result.last        = 1'b1;
                if (r_item.kind == KIND_INSERT && !r_hit) begin
                    w_cmd.insert        = 1'b1;
                    n_result.table_full = ~w_end.free_seen;
                    n_cnt               = r_period;
                end
                if (r_item.kind == KIND_QUERY && w_end.hit) begin
                    n_result.present = 1'b1;
                    if (w_end.hit_exp >= r_time) begin
                        n_result.remaining_time = w_end.hit_exp - r_time;
                    end
                end
                n_state = w_accept ? S_PRE : S_IDLE;
            end
            default: begin
                if (w_accept) begin
                    n_state = S_PRE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hit       <= 1'b0;
            r_time      <= 32'd0;
            r_cnt       <= 16'd1;
            r_period    <= 16'd1;
            r_report    <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hit       <= n_hit;
            r_time      <= n_time;
            r_cnt       <= n_cnt;
            r_res_valid <= n_res_valid;
            if (w_cfg_wr) begin
                if (paddr[2] == REG_PURGE_PERIOD) begin
                    r_period <= pwdata[15:0];
                end else begin
                    r_report <= pwdata[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

endmodule

### sv/ant_cell.sv
// One neighbor slot of the table row, with its link to the next slot.
module ant_cell
    import ant_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_chain    i_chain,
    output t_chain    o_chain
);

    logic        r_valid;
    logic [31:0] r_addr;
    logic [31:0] r_exp;
    logic [47:0] r_mac;
    logic        r_closed;

    logic w_dead;
    logic w_hit;
    logic w_pick;
    logic w_fpick;

    assign w_dead  = r_valid & ((r_exp < i_cmd.now) | r_closed);
    assign w_hit   = r_valid & (r_addr == i_cmd.key);
    assign w_pick  = w_dead & ~i_chain.dead_seen;
    assign w_fpick = ~r_valid & ~i_chain.free_seen;

    always_comb begin
        o_chain.any_valid = i_chain.any_valid | r_valid;
        o_chain.dead_seen = i_chain.dead_seen | w_dead;
        o_chain.free_seen = i_chain.free_seen | ~r_valid;
        o_chain.hit       = i_chain.hit | w_hit;
        o_chain.rep_addr  = i_chain.rep_addr | (w_pick ? r_addr : 32'd0);
        o_chain.hit_exp   = i_chain.hit_exp | (w_hit ? r_exp : 32'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.insert && w_fpick) begin
            r_valid <= 1'b1;
        end else if ((i_cmd.purge_one && w_pick) || (i_cmd.purge_all && w_dead)) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && w_fpick) begin
            r_addr   <= i_cmd.key;
            r_exp    <= i_cmd.new_exp;
            r_mac    <= i_cmd.mac;
            r_closed <= 1'b0;
        end else begin
            if (i_cmd.refresh && w_hit) begin
                if (i_cmd.new_exp > r_exp) begin
                    r_exp <= i_cmd.new_exp;
                end
                if (r_mac == 48'd0) begin
                    r_mac <= i_cmd.mac;
                end
            end
            if (i_cmd.close && r_valid && (r_mac == i_cmd.mac)) begin
                r_closed <= 1'b1;
            end
        end
    end

endmodule

### sv/ant_checker.sv
// Checker on the ports of the aging neighbor table, bound to the top level.
`include "aging_neighbor_table_unit_macros.svh"

module ant_checker
    import ant_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_valid,
    input t_result     o_result
);

    `ANT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ANT_ASSERT_NEXT(a_no_report_after_accept, i_clk, i_rst_n, start && !busy,
                     !(o_res_valid && o_result.result_kind == RES_REPORT))
    `ANT_ASSERT_NOW(a_report_shape, i_clk, i_rst_n,
                    o_res_valid && o_result.result_kind == RES_REPORT,
                    !o_result.last && !o_result.present && !o_result.table_full)
    `ANT_ASSERT_NOW(a_final_shape, i_clk, i_rst_n, o_res_valid && o_result.last,
                    o_result.result_kind == RES_FINAL && o_result.reported_address == 32'd0)

endmodule

bind aging_neighbor_table_unit ant_checker u_ant_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the aging neighbor table: directed and random items against a table model.
module testbench;
    import ant_pkg::*;

    localparam int unsigned DEPTH       = ANT_TABLE_DEPTH;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned ADDR_POOL   = 40;
    localparam int unsigned MAC_POOL    = 6;
    localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_item       i_item  = '0;
    logic        o_res_valid;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    aging_neighbor_table_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // bench copy of the neighbor table
    logic        nb_valid  [DEPTH];
    logic [31:0] nb_addr   [DEPTH];
    logic [31:0] nb_expiry [DEPTH];
    logic [47:0] nb_mac    [DEPTH];
    logic        nb_closed [DEPTH];
    logic [31:0] nb_now;
    logic [15:0] nb_countdown;
    logic [15:0] cfg_period;
    logic        cfg_report;

    t_result     expected_results[$];

    logic [31:0] addr_pool [ADDR_POOL];
    logic [47:0] mac_pool  [MAC_POOL];

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned reports_seen = 0;
    int unsigned drops_seen   = 0;
    int unsigned mismatches   = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int find_neighbor(logic [31:0] addr);
        for (int i = 0; i < DEPTH; i++) begin
            if (nb_valid[i] && nb_addr[i] == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic logic [31:0] expiry_after(logic [15:0] hold);
        logic [32:0] sum;
        sum = {1'b0, nb_now} + {17'b0, hold};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    task automatic sweep_dead_slots();
        logic    occupied;
        t_result rep;
        occupied = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            occupied = occupied | nb_valid[i];
        end
        if (!occupied) begin
            return;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (nb_valid[i] && (nb_expiry[i] < nb_now || nb_closed[i])) begin
                if (cfg_report) begin
                    rep                  = '0;
                    rep.result_kind      = RES_REPORT;
                    rep.reported_address = nb_addr[i];
                    expected_results     = {expected_results, rep};
                end
                nb_valid[i] = 1'b0;
            end
        end
        nb_countdown = cfg_period;
    endtask

    task automatic refresh_slot(int s, logic [15:0] hold, logic [47:0] mac);
        logic [31:0] e;
        e = expiry_after(hold);
        if (e > nb_expiry[s]) begin
            nb_expiry[s] = e;
        end
        if (nb_mac[s] == '0) begin
            nb_mac[s] = mac;
        end
    endtask

    task automatic predict_item(t_item it);
        int          s;
        logic        pres;
        logic [31:0] rem;
        logic        full;
        t_result     fin_word;
        pres = 1'b0;
        rem  = '0;
        full = 1'b0;
        case (it.kind)
            KIND_TICK: begin
                if (nb_now != 32'hFFFF_FFFF) begin
                    nb_now = nb_now + 32'd1;
                end
                if (nb_countdown <= 16'd1) begin
                    nb_countdown = '0;
                    sweep_dead_slots();
                end else begin
                    nb_countdown = nb_countdown - 16'd1;
                end
            end
            KIND_REFRESH: begin
                s = find_neighbor(it.neighbor_address);
                if (s >= 0) begin
                    refresh_slot(s, it.hold_time, it.link_mac);
                end
            end
            KIND_INSERT: begin
                s = find_neighbor(it.neighbor_address);
                if (s >= 0) begin
                    refresh_slot(s, it.hold_time, it.link_mac);
                end else begin
                    sweep_dead_slots();
                    for (int i = 0; i < DEPTH && s < 0; i++) begin
                        if (!nb_valid[i]) begin
                            s = i;
                        end
                    end
                    if (s < 0) begin
                        full = 1'b1;
                    end else begin
                        nb_valid[s]  = 1'b1;
                        nb_addr[s]   = it.neighbor_address;
                        nb_expiry[s] = expiry_after(it.hold_time);
                        nb_mac[s]    = it.link_mac;
                        nb_closed[s] = 1'b0;
                    end
                    nb_countdown = cfg_period;
                end
            end
            KIND_QUERY: begin
                sweep_dead_slots();
                s = find_neighbor(it.neighbor_address);
                if (s >= 0) begin
                    pres = 1'b1;
                    rem  = (nb_expiry[s] >= nb_now) ? nb_expiry[s] - nb_now : '0;
                end
            end
            KIND_TX_ERR: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (nb_valid[i] && nb_mac[i] == it.link_mac) begin
                        nb_closed[i] = 1'b1;
                    end
                end
                sweep_dead_slots();
            end
            default: ;
        endcase
        fin_word                = '0;
        fin_word.result_kind    = RES_FINAL;
        fin_word.present        = pres;
        fin_word.remaining_time = rem;
        fin_word.table_full     = full;
        fin_word.last           = 1'b1;
        expected_results        = {expected_results, fin_word};
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_res_valid === 1'b1) begin
            results_seen++;
            if (o_result.result_kind === RES_REPORT) begin
                reports_seen++;
            end
            if (o_result.table_full === 1'b1) begin
                drops_seen++;
            end
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %h", o_result);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", 32'(want.result_kind),
                            32'(o_result.result_kind));
                check_field("reported_address", want.reported_address,
                            o_result.reported_address);
                check_field("present", 32'(want.present), 32'(o_result.present));
                check_field("remaining_time", want.remaining_time,
                            o_result.remaining_time);
                check_field("table_full", 32'(want.table_full),
                            32'(o_result.table_full));
                check_field("last", 32'(want.last), 32'(o_result.last));
            end
        end
    end

    initial begin : stall_watch
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(negedge i_clk);
            if ((start && busy === 1'b0) || o_res_valid === 1'b1 || psel) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // all stimulus tasks start and end right after a rising edge
    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            nb_valid[i]  = 1'b0;
            nb_addr[i]   = '0;
            nb_expiry[i] = '0;
            nb_mac[i]    = '0;
            nb_closed[i] = 1'b0;
        end
        nb_now       = '0;
        nb_countdown = 16'd1;
        cfg_period   = 16'd1;
        cfg_report   = 1'b1;
    endtask

    task automatic send_item(t_item it);
        logic taken;
        start  <= 1'b1;
        i_item <= it;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (busy === 1'b0);
            @(posedge i_clk);
        end
        predict_item(it);
        items_sent++;
    endtask

    task automatic idle_gap(int unsigned n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0 || busy !== 1'b0);
        @(posedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(logic idx);
        logic [31:0] rd;
        apb_access(1'b0, {idx, 2'b00}, '0, rd);
        if (idx == REG_PURGE_PERIOD) begin
            check_field("prdata purge_period", {16'b0, cfg_period}, rd);
        end else begin
            check_field("prdata report_failures", {31'b0, cfg_report}, rd);
        end
    endtask

    task automatic set_register(logic idx, logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {idx, 2'b00}, value, rd);
        if (idx == REG_PURGE_PERIOD) begin
            cfg_period = value[15:0];
        end else begin
            cfg_report = value[0];
        end
        check_register(idx);
    endtask

    function automatic t_item make_item(logic [2:0] kind, logic [31:0] addr,
                                        logic [15:0] hold, logic [47:0] mac);
        t_item it;
        it.kind             = kind;
        it.neighbor_address = addr;
        it.hold_time        = hold;
        it.link_mac         = mac;
        return it;
    endfunction

    function automatic t_item random_item(logic fill);
        t_item       it;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (fill) begin
            it.kind = (r < 5)  ? KIND_TICK :
                      (r < 75) ? KIND_INSERT :
                      (r < 85) ? KIND_REFRESH :
                      (r < 95) ? KIND_QUERY :
                      (r < 99) ? KIND_TX_ERR :
                      3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end else begin
            it.kind = (r < 30) ? KIND_TICK :
                      (r < 55) ? KIND_INSERT :
                      (r < 67) ? KIND_REFRESH :
                      (r < 85) ? KIND_QUERY :
                      (r < 95) ? KIND_TX_ERR :
                      3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        end
        if ($urandom_range(0, 9) == 0) begin
            it.neighbor_address = $urandom;
        end else begin
            it.neighbor_address = addr_pool[$urandom_range(0, fill ? ADDR_POOL - 1 : 23)];
        end
        if ($urandom_range(0, 9) == 0) begin
            it.hold_time = 16'($urandom);
        end else if (fill) begin
            it.hold_time = 16'($urandom_range(1000, 65535));
        end else begin
            it.hold_time = 16'($urandom_range(0, 12));
        end
        if ($urandom_range(0, 6) == 0) begin
            it.link_mac = {16'($urandom), 32'($urandom)};
        end else begin
            it.link_mac = mac_pool[$urandom_range(0, MAC_POOL - 1)];
        end
        return it;
    endfunction

    task automatic run_random(int unsigned n, logic fill, logic gaps);
        repeat (n) begin
            if (gaps && $urandom_range(0, 4) == 0) begin
                idle_gap($urandom_range(1, 10));
            end
            send_item(random_item(fill));
        end
    endtask

    task automatic init_pools();
        addr_pool[0] = '0;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < ADDR_POOL; i++) begin
            addr_pool[i] = $urandom;
        end
        mac_pool[0] = '0;
        mac_pool[1] = 48'hFFFF_FFFF_FFFF;
        for (int i = 2; i < MAC_POOL; i++) begin
            mac_pool[i] = {16'($urandom), 32'($urandom)};
        end
    endtask

    task automatic test_register_defaults();
        check_register(REG_PURGE_PERIOD);
        check_register(REG_REPORT);
    endtask

    task automatic test_empty_table();
        send_item(make_item(KIND_QUERY, '0, '0, '0));
        send_item(make_item(KIND_TICK, '0, '0, '0));
        send_item(make_item(KIND_REFRESH, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
        send_item(make_item(KIND_TX_ERR, '0, '0, '0));
    endtask

    task automatic test_update_rules();
        send_item(make_item(KIND_INSERT, '0, '0, '0));
        send_item(make_item(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF));
        // unknown MAC gets filled in, expiry only moves forward
        send_item(make_item(KIND_REFRESH, '0, 16'd3, 48'hA5A5_0000_5A5A));
        send_item(make_item(KIND_INSERT, '0, 16'd1, 48'h0123_4567_89AB));
        send_item(make_item(KIND_QUERY, '0, '0, '0));
        send_item(make_item(KIND_QUERY, 32'hFFFF_FFFF, '0, '0));
    endtask

    task automatic test_aging();
        repeat (4) send_item(make_item(KIND_TICK, $urandom, 16'($urandom), '0));
        send_item(make_item(KIND_QUERY, '0, '0, '0));
    endtask

    task automatic test_tx_error();
        send_item(make_item(KIND_INSERT, 32'h1234_5678, 16'd100, '0));
        send_item(make_item(KIND_TX_ERR, '0, '0, '0));
        send_item(make_item(KIND_TX_ERR, '0, '0, 48'hFFFF_FFFF_FFFF));
    endtask

    task automatic test_spare_kinds();
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
            send_item(make_item(3'(k), $urandom, 16'($urandom), {16'($urandom), 32'($urandom)}));
        end
    endtask

    task automatic test_mixed_traffic();
        run_random(40, 1'b0, 1'b1);
        drain_results();
        run_random(40, 1'b0, 1'b1);
    endtask

    task automatic test_full_table();
        drain_results();
        set_register(REG_PURGE_PERIOD, 32'd65535);
        set_register(REG_REPORT, 32'd0);
        run_random(70, 1'b1, 1'b1);
    endtask

    task automatic test_frequent_purge();
        drain_results();
        set_register(REG_PURGE_PERIOD, 32'd3);
        set_register(REG_REPORT, 32'd1);
        run_random(80, 1'b0, 1'b1);
    endtask

    task automatic test_back_to_back();
        drain_results();
        set_register(REG_PURGE_PERIOD, $urandom_range(1, 6));
        set_register(REG_REPORT, $urandom_range(0, 1));
        run_random(80, 1'b0, 1'b0);
    endtask

    initial begin
        apply_reset();
        init_pools();
        test_register_defaults();
        test_empty_table();
        test_update_rules();
        test_aging();
        test_tx_error();
        test_spare_kinds();
        test_mixed_traffic();
        test_full_table();
        test_frequent_purge();
        test_back_to_back();
        drain_results();
        repeat (30) @(posedge i_clk);
        $display("run covered %0d items and %0d result words", items_sent, results_seen);
        $display("  including %0d link failure reports and %0d dropped inserts",
                 reports_seen, drops_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
